// ===== hw/rtl/bdlpr_pkg.sv =====
`default_nettype none

package bdlpr_pkg;

  localparam int unsigned ButtonCount = 3;
  localparam int unsigned RepeatLanes = 2;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned CfgW        = 16;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned EvtW        = 3;

  localparam logic [CfgIdxW-1:0] CfgDebounce  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLongPress = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRepeat    = 2'd2;

  localparam logic [CfgW-1:0] DebounceRst  = 16'd20;
  localparam logic [CfgW-1:0] LongPressRst = 16'd600;
  localparam logic [CfgW-1:0] RepeatRst    = 16'd200;

  localparam logic [EvtW-1:0] EvtNone      = 3'd0;
  localparam logic [EvtW-1:0] EvtShortBase = 3'd1;
  localparam logic [EvtW-1:0] EvtLongBase  = 3'd4;

  typedef struct packed {
    logic [CfgW-1:0] debounce;
    logic [CfgW-1:0] long_press;
    logic [CfgW-1:0] repeat_gap;
  } bdlpr_cfg_t;

  typedef struct packed {
    logic fire;
    logic is_long;
  } bdlpr_post_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bdlpr_lane.sv =====
`default_nettype none

module bdlpr_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  bdlpr_pkg::bdlpr_cfg_t     cfg_i,
  input  logic [bdlpr_pkg::TimeW-1:0] now_i,
  input  logic                      raw_pressed_i,
  input  logic                      edge_i,
  input  logic                      rpt_en_i,
  output bdlpr_pkg::bdlpr_post_t    post_o
);
  import bdlpr_pkg::*;

  logic             pressed_q, pressed_d;
  logic             long_q, long_d;
  logic [TimeW-1:0] edge_q, edge_d;
  logic [TimeW-1:0] start_q, start_d;
  logic [TimeW-1:0] rpt_q, rpt_d;
  logic [TimeW-1:0] since_edge, held, since_rpt;
  bdlpr_post_t      post;

  always_comb begin
    edge_d     = edge_i ? now_i : edge_q;
    since_edge = now_i - edge_d;
    held       = now_i - start_q;
    since_rpt  = now_i - rpt_q;
    pressed_d  = pressed_q;
    long_d     = long_q;
    start_d    = start_q;
    rpt_d      = rpt_q;
    post       = '0;
    if (raw_pressed_i != pressed_q) begin
      if (since_edge >= {{(TimeW-CfgW){1'b0}}, cfg_i.debounce}) begin
        pressed_d = raw_pressed_i;
        if (raw_pressed_i) begin
          start_d = now_i;
          rpt_d   = now_i;
          long_d  = 1'b0;
        end else if (!long_q) begin
          post.fire = 1'b1;
        end
      end
    end else if (pressed_q) begin
      if (!long_q && held >= {{(TimeW-CfgW){1'b0}}, cfg_i.long_press}) begin
        post.fire    = 1'b1;
        post.is_long = 1'b1;
        long_d       = 1'b1;
        rpt_d        = now_i;
      end else if (long_q && since_rpt >= {{(TimeW-CfgW){1'b0}}, cfg_i.repeat_gap}) begin
        post.fire    = rpt_en_i;
        post.is_long = 1'b1;
        rpt_d        = now_i;
      end
    end
  end

  assign post_o = post;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= 1'b0;
      long_q    <= 1'b0;
      edge_q    <= '0;
      start_q   <= '0;
      rpt_q     <= '0;
    end else if (accept_i) begin
      pressed_q <= pressed_d;
      long_q    <= long_d;
      edge_q    <= edge_d;
      start_q   <= start_d;
      rpt_q     <= rpt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bdlpr_merge.sv =====
`default_nettype none

module bdlpr_merge (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   take_event_i,
  input  bdlpr_pkg::bdlpr_post_t posts_i [bdlpr_pkg::ButtonCount],
  output logic                   accept_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [bdlpr_pkg::EvtW-1:0] pending_event_o
);
  import bdlpr_pkg::*;

  logic [EvtW-1:0] latch_q, latch_d;
  logic [EvtW-1:0] polled;
  logic            out_valid_q, skid_valid_q;
  logic [EvtW-1:0] out_data_q, skid_data_q;
  logic            accept, pop;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign pop        = out_valid_q && !out_stall_i;
  assign accept_o   = accept;

  always_comb begin
    polled = latch_q;
    for (int b = 0; b < ButtonCount; b++) begin
      if (posts_i[b].fire) begin
        polled = (posts_i[b].is_long ? EvtLongBase : EvtShortBase) + EvtW'(b);
      end
    end
    latch_d = take_event_i ? EvtNone : polled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q      <= EvtNone;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        latch_q <= latch_d;
      end
      if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else if (!accept) begin
          out_valid_q <= 1'b0;
        end
      end else if (accept) begin
        if (out_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (accept) begin
        out_data_q <= polled;
      end
    end else if (accept) begin
      if (out_valid_q) begin
        skid_data_q <= polled;
      end else begin
        out_data_q <= polled;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pending_event_o = out_data_q;

`ifndef SYNTH
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q) else $error("skid holds data while output is empty");
  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_event_o != 3'd7) else $error("invalid event code");
  a_take_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && take_event_i |=> latch_q == EvtNone) else $error("take did not clear event");
  a_latch_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(latch_q)) else $error("event latch moved without a transaction");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/button_debounce_long_press_repeat.sv =====
// Debounce and long press for three active-low buttons (up, down, set), auto repeat for up and down.
// Input channel: in_valid_i / in_stall_o carry one poll tick per transaction:
//   now_ms_i (ms timestamp), pin_levels_i (0 = pressed), edge_mask_i, take_event_i.
// Output channel: out_valid_o / out_stall_i carry pending_event_o, the pending event
//   after this tick's polling (0 none, 1..3 short, 4..6 long for up, down, set).
//   With take_event_i set, the pending event is cleared after it is reported.
// Config channel: cfg_valid_i / cfg_ready_o, cfg_index_i selects debounce (0),
//   long press (1) or repeat (2) time, cfg_data_i is the value in ms; index 3 is ignored.
//   cfg_ready_o is always high; write only while the block is idle.
// Throughput: one tick per cycle while in_stall_o is low; the three buttons are handled
//   by parallel lanes, resolved combinationally by the merge stage, set over down over up.
// Results are registered in the output entry, or in the skid entry while that one is full.
// A two-entry output buffer lets a tick be accepted while a result waits; in_stall_o
//   rises only when both entries are full and the receiver stalls.
// Reset: all buttons released, timestamps zero, no pending event, registers at
//   20 / 600 / 200 ms, output buffer empty.
`default_nettype none

module button_debounce_long_press_repeat (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [bdlpr_pkg::TimeW-1:0]        now_ms_i,
  input  logic [bdlpr_pkg::ButtonCount-1:0]  pin_levels_i,
  input  logic [bdlpr_pkg::ButtonCount-1:0]  edge_mask_i,
  input  logic                               take_event_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bdlpr_pkg::EvtW-1:0]         pending_event_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bdlpr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [bdlpr_pkg::CfgW-1:0]         cfg_data_i
);
  import bdlpr_pkg::*;

  bdlpr_cfg_t  cfg_q;
  bdlpr_post_t posts [ButtonCount];
  logic        accept;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce   <= DebounceRst;
      cfg_q.long_press <= LongPressRst;
      cfg_q.repeat_gap <= RepeatRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgDebounce:  cfg_q.debounce   <= cfg_data_i;
        CfgLongPress: cfg_q.long_press <= cfg_data_i;
        CfgRepeat:    cfg_q.repeat_gap <= cfg_data_i;
        default: ;
      endcase
    end
  end

  for (genvar b = 0; b < ButtonCount; b++) begin : g_lane
    bdlpr_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .accept_i      (accept),
      .cfg_i         (cfg_q),
      .now_i         (now_ms_i),
      .raw_pressed_i (!pin_levels_i[b]),
      .edge_i        (edge_mask_i[b]),
      .rpt_en_i      (b < RepeatLanes),
      .post_o        (posts[b])
    );
  end

  bdlpr_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .take_event_i    (take_event_i),
    .posts_i         (posts),
    .accept_o        (accept),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pending_event_o (pending_event_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_button_debounce_long_press_repeat.sv =====
`timescale 1ns / 100ps

module tb_button_debounce_long_press_repeat;
  import bdlpr_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int unsigned TimeoutNs = 12_000_000;

  class event_scoreboard;
    logic [CfgW-1:0] deb_time;
    logic [CfgW-1:0] long_ms;
    logic [CfgW-1:0] rpt_time;
    logic [ButtonCount-1:0] held;
    logic [ButtonCount-1:0] long_seen;
    logic [TimeW-1:0] edge_at[ButtonCount];
    logic [TimeW-1:0] press_at[ButtonCount];
    logic [TimeW-1:0] repeat_at[ButtonCount];
    logic [EvtW-1:0] latch;
    logic [EvtW-1:0] expected_events[$];
    int unsigned mismatches;

    function new();
      deb_time = DebounceRst;
      long_ms = LongPressRst;
      rpt_time = RepeatRst;
      held = '0;
      long_seen = '0;
      latch = EvtNone;
      mismatches = 0;
      for (int unsigned b = 0; b < ButtonCount; b++) begin
        edge_at[b] = '0;
        press_at[b] = '0;
        repeat_at[b] = '0;
      end
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      case (idx)
        CfgDebounce: deb_time = val;
        CfgLongPress: long_ms = val;
        CfgRepeat: rpt_time = val;
        default: ;
      endcase
    endfunction

    function void poll_button(int unsigned b, logic pressed, logic [TimeW-1:0] now);
      logic [TimeW-1:0] since_edge;
      logic [TimeW-1:0] hold_ms;
      logic [TimeW-1:0] since_repeat;
      since_edge = now - edge_at[b];
      hold_ms = now - press_at[b];
      since_repeat = now - repeat_at[b];
      if (pressed != held[b]) begin
        if (since_edge >= TimeW'(deb_time)) begin
          held[b] = pressed;
          if (pressed) begin
            press_at[b] = now;
            repeat_at[b] = now;
            long_seen[b] = 1'b0;
          end else if (!long_seen[b]) begin
            latch = EvtShortBase + EvtW'(b);
          end
        end
      end else if (held[b]) begin
        if (!long_seen[b] && hold_ms >= TimeW'(long_ms)) begin
          latch = EvtLongBase + EvtW'(b);
          long_seen[b] = 1'b1;
          repeat_at[b] = now;
        end else if (long_seen[b] && since_repeat >= TimeW'(rpt_time)) begin
          if (b < RepeatLanes) latch = EvtLongBase + EvtW'(b);
          repeat_at[b] = now;
        end
      end
    endfunction

    function void note_tick(logic [TimeW-1:0] now, logic [ButtonCount-1:0] levels,
                            logic [ButtonCount-1:0] edges, logic take);
      for (int unsigned b = 0; b < ButtonCount; b++)
        if (edges[b]) edge_at[b] = now;
      for (int unsigned b = 0; b < ButtonCount; b++)
        poll_button(b, !levels[b], now);
      expected_events.push_back(latch);
      if (take) latch = EvtNone;
    endfunction

    function void check_event(logic [EvtW-1:0] got);
      logic [EvtW-1:0] want;
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected pending_event, expected none, actual %0d", $time, got);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        if (got !== want) begin
          $display("%0t: pending_event expected %0d, actual %0d", $time, want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [TimeW-1:0] now_ms_i;
  logic [ButtonCount-1:0] pin_levels_i;
  logic [ButtonCount-1:0] edge_mask_i;
  logic take_event_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [EvtW-1:0] pending_event_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0] cfg_data_i;

  event_scoreboard board = new();

  logic tx_throttle;
  logic rx_throttle;
  logic [TimeW-1:0] tick_ms;
  logic [ButtonCount-1:0] pin_last;
  logic [ButtonCount-1:0] pin_target;
  int unsigned bounce_left[ButtonCount];

  button_debounce_long_press_repeat uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .now_ms_i(now_ms_i),
    .pin_levels_i(pin_levels_i),
    .edge_mask_i(edge_mask_i),
    .take_event_i(take_event_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .pending_event_o(pending_event_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutNs);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        out_stall_i = 1'b0;
        if (rx_throttle) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_event(pending_event_o);
  end

  task automatic send_tick(input logic [TimeW-1:0] now, input logic [ButtonCount-1:0] levels,
                           input logic [ButtonCount-1:0] edges, input logic take);
    int unsigned gap;
    gap = tx_throttle ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    now_ms_i = now;
    pin_levels_i = levels;
    edge_mask_i = edges;
    take_event_i = take;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    board.note_tick(now, levels, edges, take);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (board.expected_events.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    board.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_times(input logic [CfgW-1:0] deb, input logic [CfgW-1:0] lng,
                           input logic [CfgW-1:0] rpt);
    wait_drained();
    write_reg(CfgDebounce, deb);
    write_reg(CfgLongPress, lng);
    write_reg(CfgRepeat, rpt);
    tx_throttle = ($urandom_range(0, 3) != 0);
    rx_throttle = ($urandom_range(0, 3) != 0);
  endtask

  task automatic gen_tick(input int unsigned step_max, input int unsigned big_step,
                          input int unsigned toggle_pct, input int unsigned noise_pct);
    logic [ButtonCount-1:0] levels;
    logic [ButtonCount-1:0] edges;
    logic take;
    take = ($urandom_range(0, 2) == 0);
    if ($urandom_range(0, 99) < noise_pct) begin
      tick_ms = $urandom;
      levels = ButtonCount'($urandom);
      edges = ButtonCount'($urandom);
    end else begin
      if ($urandom_range(0, 9) == 0) tick_ms = tick_ms + TimeW'($urandom_range(0, big_step));
      else tick_ms = tick_ms + TimeW'($urandom_range(0, step_max));
      for (int unsigned b = 0; b < ButtonCount; b++) begin
        if (bounce_left[b] != 0) begin
          levels[b] = 1'($urandom_range(0, 1));
          bounce_left[b]--;
        end else begin
          if ($urandom_range(0, 99) < toggle_pct) begin
            pin_target[b] = ~pin_target[b];
            bounce_left[b] = $urandom_range(0, 3);
          end
          levels[b] = pin_target[b];
        end
      end
      edges = levels ^ pin_last;
      if ($urandom_range(0, 19) == 0) edges = edges | ButtonCount'($urandom);
    end
    pin_last = levels;
    send_tick(tick_ms, levels, edges, take);
  endtask

  task automatic run_phase(input int unsigned items, input int unsigned step_max,
                           input int unsigned big_step, input int unsigned toggle_pct,
                           input int unsigned noise_pct);
    for (int unsigned i = 0; i < items; i++) begin
      if ($urandom_range(0, 39) == 0) tx_throttle = ~tx_throttle;
      if ($urandom_range(0, 39) == 0) rx_throttle = ~rx_throttle;
      gen_tick(step_max, big_step, toggle_pct, noise_pct);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    now_ms_i = '0;
    pin_levels_i = '1;
    edge_mask_i = '0;
    take_event_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgDebounce;
    cfg_data_i = '0;
    tx_throttle = 1'b1;
    rx_throttle = 1'b1;
    tick_ms = '0;
    pin_last = '1;
    pin_target = '1;
    for (int unsigned b = 0; b < ButtonCount; b++) bounce_left[b] = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_tick(32'd0, 3'b111, 3'b000, 1'b0);
    send_tick(32'd25, 3'b110, 3'b000, 1'b0);
    send_tick(32'd30, 3'b111, 3'b001, 1'b0);
    send_tick(32'd50, 3'b111, 3'b000, 1'b1);
    send_tick(32'd60, 3'b100, 3'b011, 1'b0);
    send_tick(32'd80, 3'b100, 3'b000, 1'b0);
    send_tick(32'd680, 3'b100, 3'b000, 1'b1);
    send_tick(32'd880, 3'b100, 3'b000, 1'b0);
    send_tick(32'd1080, 3'b000, 3'b100, 1'b1);
    send_tick(32'd1100, 3'b000, 3'b000, 1'b0);
    send_tick(32'd1700, 3'b000, 3'b000, 1'b1);
    send_tick(32'd1900, 3'b000, 3'b000, 1'b0);
    send_tick(32'd1910, 3'b111, 3'b111, 1'b0);
    send_tick(32'd1930, 3'b111, 3'b000, 1'b1);
    send_tick(32'd1940, 3'b000, 3'b111, 1'b0);
    send_tick(32'd1960, 3'b000, 3'b000, 1'b0);
    send_tick(32'd1970, 3'b111, 3'b111, 1'b0);
    send_tick(32'd1990, 3'b111, 3'b000, 1'b1);
    send_tick(32'hFFFF_FFF0, 3'b110, 3'b001, 1'b0);
    send_tick(32'hFFFF_FFFF, 3'b110, 3'b000, 1'b0);
    send_tick(32'h0000_0004, 3'b110, 3'b000, 1'b0);
    send_tick(32'd604, 3'b110, 3'b000, 1'b1);
    send_tick(32'd610, 3'b111, 3'b001, 1'b0);

    set_times(16'd0, 16'd0, 16'd0);
    write_reg(CfgUnused, 16'hFFFF);
    send_tick(32'd700, 3'b101, 3'b010, 1'b0);
    send_tick(32'd700, 3'b101, 3'b000, 1'b0);
    send_tick(32'd700, 3'b101, 3'b000, 1'b1);
    send_tick(32'd701, 3'b111, 3'b010, 1'b1);

    set_times(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(32'd800, 3'b011, 3'b100, 1'b0);
    send_tick(32'd800 + 32'd65534, 3'b011, 3'b000, 1'b0);
    send_tick(32'd800 + 32'd65535, 3'b011, 3'b000, 1'b0);
    send_tick(32'd800 + 32'd131070, 3'b011, 3'b000, 1'b1);
    send_tick(32'd800 + 32'd131071, 3'b111, 3'b100, 1'b0);
    tick_ms = 32'd800 + 32'd131071;

    set_times(16'($urandom_range(1, 6)), 16'($urandom_range(15, 40)),
              16'($urandom_range(3, 10)));
    run_phase(100, 4, 40, 8, 5);

    set_times(16'd0, 16'($urandom_range(0, 4)), 16'($urandom_range(0, 2)));
    run_phase(100, 2, 10, 10, 5);

    tick_ms = 32'hFFFF_FFFF - TimeW'($urandom_range(0, 20000));
    set_times(DebounceRst, LongPressRst, RepeatRst);
    run_phase(100, 60, 1500, 6, 5);

    set_times(16'($urandom), 16'($urandom), 16'($urandom));
    run_phase(100, 3000, 70000, 10, 10);

    set_times(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(100, 20000, 70000, 15, 5);

    set_times(16'($urandom_range(0, 8)), 16'($urandom_range(10, 60)),
              16'($urandom_range(0, 15)));
    run_phase(50, 5, 80, 8, 5);
    wait_drained();
    run_phase(50, 5, 80, 8, 5);

    set_times(16'($urandom_range(0, 8)), 16'($urandom_range(10, 60)),
              16'($urandom_range(0, 15)));
    run_phase(100, 5, 80, 8, 10);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_events.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
